// ----- rtl/ple_pkg.sv -----
package ple_pkg;

  // Default number of list entries.
  localparam int CAPACITY_DEF = 16;

  // Width of the data, position and length fields.
  localparam int DATA_W = 32;
  localparam int POS_W  = 5;

  // Operation codes of an input transaction.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  // Status codes of a result transaction.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // Input transaction payload.
  typedef struct packed {
    op_t                      op;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] value_out;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         length_out;
  } out_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic                     ins_en;
    logic                     del_en;
    logic [POS_W-1:0]         slot;
    logic signed [DATA_W-1:0] data;
  } cmd_t;

endpackage

// ----- rtl/ple_cell.sv -----
module ple_cell #(
  parameter int IDX = 0
) (
  input  logic                             clk,
  input  ple_pkg::cmd_t                    cmd,
  input  logic signed [ple_pkg::DATA_W-1:0] left_i,
  input  logic signed [ple_pkg::DATA_W-1:0] right_i,
  output logic signed [ple_pkg::DATA_W-1:0] entry_o,
  output logic                             match_o
);

  logic signed [ple_pkg::DATA_W-1:0] entry_r;
  logic signed [ple_pkg::DATA_W-1:0] entry_nxt;

  // Insert moves entries above the slot up one place and writes the slot;
  // delete pulls every entry from the slot upward down one place.
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins_en) begin
      if (IDX > int'(cmd.slot)) begin
        entry_nxt = left_i;
      end else if (IDX == int'(cmd.slot)) begin
        entry_nxt = cmd.data;
      end
    end else if (cmd.del_en) begin
      if (IDX >= int'(cmd.slot)) begin
        entry_nxt = right_i;
      end
    end
  end

  // The entry holds no reset value; it is only read after being written.
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // Compare against the search key carried on the command.
  assign entry_o = entry_r;
  assign match_o = (entry_r == cmd.data);

endmodule

// ----- rtl/positional_list_engine_unit.sv -----
// Positional list engine: an ordered list of signed 32-bit values held in a
// row of cells, one entry per cell, with a length count.
// Input channel (in_valid, in_stall, in_data) carries one operation per
// transaction: insert, delete or find at a 1-based position, or search for a
// value. Result channel (out_valid, out_stall, out_data) returns exactly one
// result transaction per input transaction, in order.
// All cells shift, load or compare in parallel, so the result is registered
// at the edge that accepts the input. An input transaction can be taken every
// cycle while the receiver does not stall; the result passes through a single
// output register.
// When the receiver stalls, the result stays in the output register and
// in_stall rises until the result has been taken, so nothing is lost.
// Reset (rst_n low at a clock edge) empties the list and drops any pending
// result; cell contents are not cleared and are never read before written.
// Out-of-range positions return an out-of-bounds status and an insert into
// a full list returns a full status; the list is left unchanged in both.
module positional_list_engine_unit #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ple_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ple_pkg::out_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W) + 1;
  localparam int RD_N  = (CAPACITY < (1 << ple_pkg::POS_W)) ? CAPACITY
                                                             : (1 << ple_pkg::POS_W);

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  ple_pkg::out_t     out_data_r;
  ple_pkg::out_t     out_data_nxt;

  logic              take;
  logic [CMP_W-1:0]  pos_w;
  logic [CMP_W-1:0]  cnt_w;
  logic [CMP_W-1:0]  cnt_nxt_w;
  logic              ins_pos_ok;
  logic              rd_pos_ok;
  logic              full;
  ple_pkg::cmd_t     cmd;

  logic signed [ple_pkg::DATA_W-1:0] entry [CAPACITY];
  logic signed [ple_pkg::DATA_W-1:0] rd_val;
  logic [CAPACITY-1:0]               match;
  logic [CAPACITY-1:0]               hit;
  logic [ple_pkg::POS_W-1:0]         hit_pos;

  // A new transaction waits only while a result is held by the receiver.
  assign in_stall = out_valid_r && out_stall;
  assign take     = in_valid && !in_stall;

  // Position checks against the current length.
  assign pos_w      = CMP_W'(in_data.position);
  assign cnt_w      = CMP_W'(count_r);
  assign ins_pos_ok = (in_data.position != '0) && (pos_w <= cnt_w + CMP_W'(1));
  assign rd_pos_ok  = (in_data.position != '0) && (pos_w <= cnt_w);
  assign full       = (count_r == CNT_W'(CAPACITY));

  // Command broadcast to the cell row.
  always_comb begin
    cmd.ins_en = take && (in_data.op == ple_pkg::OP_INSERT) && ins_pos_ok && !full;
    cmd.del_en = take && (in_data.op == ple_pkg::OP_DELETE) && rd_pos_ok;
    cmd.slot   = in_data.position - ple_pkg::POS_W'(1);
    cmd.data   = in_data.value;
  end

  // Row of cells; each one sees its two neighbors.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [ple_pkg::DATA_W-1:0] left_v;
    logic signed [ple_pkg::DATA_W-1:0] right_v;

    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_left
      assign left_v = entry[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_right
      assign right_v = entry[g+1];
    end

    ple_cell #(
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .left_i  (left_v),
      .right_i (right_v),
      .entry_o (entry[g]),
      .match_o (match[g])
    );

    // Only cells inside the list take part in a search.
    assign hit[g] = match[g] && (CNT_W'(g) < count_r);
  end

  // Entry at the requested slot for find and delete.
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (int'(cmd.slot) == i) begin
        rd_val = entry[i];
      end
    end
  end

  // First occupied cell that holds the search key.
  always_comb begin
    hit_pos = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_pos = ple_pkg::POS_W'(i + 1);
      end
    end
  end

  // Next length and the result of the accepted transaction.
  always_comb begin
    count_nxt                   = count_r;
    out_data_nxt.status         = ple_pkg::ST_OK;
    out_data_nxt.value_out      = '0;
    out_data_nxt.found_position = '0;
    unique case (in_data.op)
      ple_pkg::OP_INSERT: begin
        if (!ins_pos_ok) begin
          out_data_nxt.status = ple_pkg::ST_BOUNDS;
        end else if (full) begin
          out_data_nxt.status = ple_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ple_pkg::OP_DELETE: begin
        if (!rd_pos_ok) begin
          out_data_nxt.status = ple_pkg::ST_BOUNDS;
        end else begin
          out_data_nxt.value_out = rd_val;
          count_nxt              = count_r - CNT_W'(1);
        end
      end
      ple_pkg::OP_FIND: begin
        if (!rd_pos_ok) begin
          out_data_nxt.status = ple_pkg::ST_BOUNDS;
        end else begin
          out_data_nxt.value_out = rd_val;
        end
      end
      ple_pkg::OP_SEARCH: begin
        out_data_nxt.found_position = hit_pos;
      end
      default: begin
        out_data_nxt.status = ple_pkg::ST_OK;
      end
    endcase
    cnt_nxt_w               = CMP_W'(count_nxt);
    out_data_nxt.length_out = cnt_nxt_w[ple_pkg::POS_W-1:0];
  end

  // Output register holds a result until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An insert and a delete are never issued to the row together.
  a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.ins_en && cmd.del_en))
    else $error("insert and delete issued together");

  // The length never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("list length beyond capacity");

  // A successful insert grows the list by exactly one.
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_en |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the list by one");

  // A successful delete shrinks the list by exactly one.
  a_del_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.del_en |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("delete did not shrink the list by one");

  // A full status is only shown while the list is at capacity.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == ple_pkg::ST_FULL))
      |-> (count_r == CNT_W'(CAPACITY)))
    else $error("full status reported with room left");

endmodule

// ----- test/positional_list_engine_unit_tb.sv -----
`timescale 1ns / 100ps

module positional_list_engine_unit_tb;

  localparam int CAP            = ple_pkg::CAPACITY_DEF;
  localparam int RAND_PER_PHASE = 650;
  localparam int HOLD_CYCLES    = 120;
  localparam int DRAIN_CYCLES   = 8;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int REPORT_LIMIT   = 10;
  localparam int DIR_ROWS       = 22;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  ple_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  ple_pkg::out_t out_data;

  // One row of the directed table; the result is typed in only where typed is set.
  typedef struct {
    ple_pkg::op_t                      op;
    logic [ple_pkg::POS_W-1:0]         pos;
    logic signed [ple_pkg::DATA_W-1:0] val;
    int                                reps;
    bit                                typed;
    ple_pkg::out_t                     want;
  } dir_row_t;

  dir_row_t dir_table [DIR_ROWS] = '{
    // Empty list: the positions tried are out of bounds, search misses.
    '{ple_pkg::OP_FIND,   5'd0,  32'sd0, 1, 1'b1, '{ple_pkg::ST_BOUNDS, 32'sd0, 5'd0, 5'd0}},
    '{ple_pkg::OP_DELETE, 5'd1,  32'sd0, 1, 1'b1, '{ple_pkg::ST_BOUNDS, 32'sd0, 5'd0, 5'd0}},
    '{ple_pkg::OP_SEARCH, 5'd0,  32'sd0, 1, 1'b1, '{ple_pkg::ST_OK,     32'sd0, 5'd0, 5'd0}},
    '{ple_pkg::OP_INSERT, 5'd0,  32'sd5, 1, 1'b1, '{ple_pkg::ST_BOUNDS, 32'sd0, 5'd0, 5'd0}},
    '{ple_pkg::OP_INSERT, 5'd2,  32'sd5, 1, 1'b1, '{ple_pkg::ST_BOUNDS, 32'sd0, 5'd0, 5'd0}},
    // Extreme values at the front and at the end.
    '{ple_pkg::OP_INSERT, 5'd1,  32'sh7FFFFFFF, 1, 1'b1, '{ple_pkg::ST_OK, 32'sd0, 5'd0, 5'd1}},
    '{ple_pkg::OP_INSERT, 5'd1,  32'sh80000000, 1, 1'b1, '{ple_pkg::ST_OK, 32'sd0, 5'd0, 5'd2}},
    '{ple_pkg::OP_INSERT, 5'd3,  32'shFFFFFFFF, 1, 1'b1, '{ple_pkg::ST_OK, 32'sd0, 5'd0, 5'd3}},
    '{ple_pkg::OP_FIND,   5'd1,  32'sd0, 1, 1'b1, '{ple_pkg::ST_OK, 32'sh80000000, 5'd0, 5'd3}},
    '{ple_pkg::OP_FIND,   5'd31, 32'sd0, 1, 1'b1, '{ple_pkg::ST_BOUNDS, 32'sd0, 5'd0, 5'd3}},
    // Search ignores the position field.
    '{ple_pkg::OP_SEARCH, 5'd31, 32'sh7FFFFFFF, 1, 1'b1, '{ple_pkg::ST_OK, 32'sd0, 5'd2, 5'd3}},
    '{ple_pkg::OP_INSERT, 5'd2,  32'sd0, 1, 1'b0, '0},
    '{ple_pkg::OP_DELETE, 5'd4,  32'sd0, 1, 1'b0, '0},
    // Fill the list up to capacity.
    '{ple_pkg::OP_INSERT, 5'd1,  32'sd1234, 13, 1'b0, '0},
    // Full store, and the position check ahead of the full check.
    '{ple_pkg::OP_INSERT, 5'd17, 32'sd9, 1, 1'b1, '{ple_pkg::ST_FULL,   32'sd0, 5'd0, 5'd16}},
    '{ple_pkg::OP_INSERT, 5'd18, 32'sd9, 1, 1'b1, '{ple_pkg::ST_BOUNDS, 32'sd0, 5'd0, 5'd16}},
    '{ple_pkg::OP_SEARCH, 5'd0,  32'shFFFFFFFF, 1, 1'b0, '0},
    '{ple_pkg::OP_SEARCH, 5'd0,  32'sd0, 1, 1'b0, '0},
    '{ple_pkg::OP_FIND,   5'd16, 32'sd0, 1, 1'b0, '0},
    '{ple_pkg::OP_DELETE, 5'd0,  32'sd0, 1, 1'b1, '{ple_pkg::ST_BOUNDS, 32'sd0, 5'd0, 5'd16}},
    '{ple_pkg::OP_DELETE, 5'd1,  32'sd0, 1, 1'b0, '0},
    '{ple_pkg::OP_DELETE, 5'd15, 32'sd0, 1, 1'b0, '0}
  };

  // Shadow copy of the list, updated as each input transaction is accepted.
  logic signed [ple_pkg::DATA_W-1:0] shadow_entries [CAP];
  int                                shadow_len = 0;
  bit                                filling = 1'b1;

  ple_pkg::out_t pending_results [$];
  int            fail_count  = 0;
  int            cycle_count = 0;
  int            tx_idle_pct = 17;
  int            rx_idle_pct = 71;
  bit            hold_req    = 1'b0;

  positional_list_engine_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one operation to the shadow list and return the result it should give.
  function automatic ple_pkg::out_t list_apply(ple_pkg::in_t item);
    ple_pkg::out_t res;
    int            p;
    int            i;
    res = '0;
    p = int'(item.position);
    case (item.op)
      ple_pkg::OP_INSERT: begin
        if (p < 1 || p > shadow_len + 1) begin
          res.status = ple_pkg::ST_BOUNDS;
        end else if (shadow_len >= CAP) begin
          res.status = ple_pkg::ST_FULL;
        end else begin
          for (i = shadow_len; i >= p; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[p-1] = item.value;
          shadow_len++;
        end
      end
      ple_pkg::OP_DELETE: begin
        if (p < 1 || p > shadow_len) begin
          res.status = ple_pkg::ST_BOUNDS;
        end else begin
          res.value_out = shadow_entries[p-1];
          for (i = p; i < shadow_len; i++) shadow_entries[i-1] = shadow_entries[i];
          shadow_len--;
        end
      end
      ple_pkg::OP_FIND: begin
        if (p < 1 || p > shadow_len) res.status = ple_pkg::ST_BOUNDS;
        else res.value_out = shadow_entries[p-1];
      end
      default: begin
        for (i = 0; i < shadow_len; i++) begin
          if (res.found_position == '0 && shadow_entries[i] == item.value) begin
            res.found_position = ple_pkg::POS_W'(i + 1);
          end
        end
      end
    endcase
    res.length_out = ple_pkg::POS_W'(shadow_len);
    return res;
  endfunction

  // Random operation, biased toward legal positions and toward filling or
  // draining the list so that both the full and the empty edge are reached.
  function automatic ple_pkg::in_t pick_item();
    ple_pkg::in_t item;
    int           r;
    int           hi;
    r = $urandom_range(0, 99);
    if (filling) begin
      item.op = (r < 45) ? ple_pkg::OP_INSERT :
                (r < 60) ? ple_pkg::OP_DELETE :
                (r < 80) ? ple_pkg::OP_FIND : ple_pkg::OP_SEARCH;
    end else begin
      item.op = (r < 15) ? ple_pkg::OP_INSERT :
                (r < 60) ? ple_pkg::OP_DELETE :
                (r < 80) ? ple_pkg::OP_FIND : ple_pkg::OP_SEARCH;
    end
    hi = (item.op == ple_pkg::OP_INSERT) ? shadow_len + 1 : shadow_len;
    if ($urandom_range(0, 99) < 85 && hi > 0) begin
      item.position = ple_pkg::POS_W'($urandom_range(1, hi));
    end else begin
      item.position = ple_pkg::POS_W'($urandom_range(0, 31));
    end
    r = $urandom_range(0, 99);
    if (r < 40) begin
      item.value = $urandom();
    end else if (r < 65) begin
      // Small values make duplicates, so search must return the first hit.
      item.value = ple_pkg::DATA_W'($urandom_range(0, 7)) - 32'sd3;
    end else if (r < 80) begin
      case ($urandom_range(0, 3))
        0:       item.value = 32'sh7FFFFFFF;
        1:       item.value = 32'sh80000000;
        2:       item.value = 32'shFFFFFFFF;
        default: item.value = 32'sd0;
      endcase
    end else if (shadow_len > 0) begin
      item.value = shadow_entries[$urandom_range(0, shadow_len - 1)];
    end else begin
      item.value = $urandom();
    end
    return item;
  endfunction

  // Offer one input transaction after a random gap and record its expected result.
  task automatic send_item(input ple_pkg::in_t item, input bit typed,
                           input ple_pkg::out_t want);
    ple_pkg::out_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = list_apply(item);
    pending_results.push_back(typed ? want : predicted);
    if (shadow_len == CAP && $urandom_range(0, 99) < 25) filling = 1'b0;
    else if (shadow_len == 0) filling = 1'b1;
  endtask

  // Stimulus: reset, directed table, then three random phases.
  initial begin
    ple_pkg::in_t item;
    int           k;
    int           n;
    int           ph;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIR_ROWS; k++) begin
      for (n = 0; n < dir_table[k].reps; n++) begin
        item.op       = dir_table[k].op;
        item.position = dir_table[k].pos;
        item.value    = dir_table[k].val + n;
        send_item(item, dir_table[k].typed, dir_table[k].want);
      end
    end

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 17;
          rx_idle_pct = 71;
        end
        1: begin
          tx_idle_pct = 71;
          rx_idle_pct = 17;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_req    = 1'b1;
        end
      endcase
      for (n = 0; n < RAND_PER_PHASE; n++) send_item(pick_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off when requested so the
  // block fills up and stalls its input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Compare each accepted result transaction with the oldest expectation.
  always @(posedge clk) begin
    ple_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("Unexpected result: status=%0d value_out=%h found=%0d len=%0d",
                   out_data.status, out_data.value_out, out_data.found_position,
                   out_data.length_out);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.value_out !== want.value_out ||
            out_data.found_position !== want.found_position ||
            out_data.length_out !== want.length_out) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("Mismatch: expected status=%0d value_out=%h found=%0d len=%0d",
                     want.status, want.value_out, want.found_position, want.length_out);
            $display("          actual   status=%0d value_out=%h found=%0d len=%0d",
                     out_data.status, out_data.value_out, out_data.found_position,
                     out_data.length_out);
          end
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/positional_list_engine_unit.sv
test/positional_list_engine_unit_tb.sv
